// ----- rtl/rational_arithmetic_unit_top_assert.svh -----
// Assertion macros shared by the RTL of the rational arithmetic unit.
`ifndef RATIONAL_ARITHMETIC_UNIT_TOP_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_TOP_ASSERT_SVH

// Checks an implication on every clock edge outside reset.
`define RAU_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Checks a consequence in the cycle after the antecedent.
`define RAU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/rau_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rau_pkg;

    // Operation codes.
    localparam logic [3:0] OP_ADD = 4'd0;
    localparam logic [3:0] OP_SUB = 4'd1;
    localparam logic [3:0] OP_MUL = 4'd2;
    localparam logic [3:0] OP_DIV = 4'd3;
    localparam logic [3:0] OP_EQ  = 4'd4;
    localparam logic [3:0] OP_NE  = 4'd5;
    localparam logic [3:0] OP_LT  = 4'd6;
    localparam logic [3:0] OP_LE  = 4'd7;
    localparam logic [3:0] OP_GT  = 4'd8;
    localparam logic [3:0] OP_GE  = 4'd9;

    // One request item.
    typedef struct packed {
        logic [3:0]         op;
        logic signed [31:0] a_num;
        logic signed [31:0] a_den;
        logic signed [31:0] b_num;
        logic signed [31:0] b_den;
    } t_req;

    // One result item.
    typedef struct packed {
        logic signed [31:0] res_num;
        logic [30:0]        res_den;
        logic               cmp_true;
        logic               div_zero;
        logic               overflow;
    } t_res;

    // Magnitude of a 32-bit two's complement value.
    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/rational_arithmetic_unit_top.sv -----
// Rational arithmetic unit.
// A request item is taken when start is high and busy is low. It holds an
// opcode and two fractions; each fraction is reduced, then added, subtracted,
// multiplied, divided or compared, and the result is reduced again.
// The result item appears on o_res for exactly one cycle with o_done high;
// the receiver must take it then, it cannot stall the block.
// Busy stays high from the cycle after acceptance until o_done is shown;
// a new item may be started in the cycle that o_done is high.
// Each reduction of a nonzero numerator runs a binary GCD of one shift or
// compare/subtract per cycle and two bit-serial exact divisions of 64 bits.
// Compares need no GCD in the final reduction. The block takes no new item
// until the last one is done; the next item may start in the strobe cycle.
// One 32x32 multiplier and one 64-bit divider step are shared.
// Synchronous active-low reset returns the sequencer to idle and clears
// o_done; no result is pending after reset.
`timescale 1ns / 1ps
`default_nettype none

module rational_arithmetic_unit_top #(
    parameter int WIDTH = 32
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               start,
    output logic              busy,
    input  wire rau_pkg::t_req i_req,
    output rau_pkg::t_res     o_res,
    output logic              o_done
);

`include "rational_arithmetic_unit_top_assert.svh"

    localparam logic [63:0] PMAX = (64'd1 << (WIDTH - 1)) - 64'd1;
    localparam logic [63:0] NMAX = 64'd1 << (WIDTH - 1);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_RED  = 9'b000000010,
        S_GSH  = 9'b000000100,
        S_GLP  = 9'b000001000,
        S_DVN  = 9'b000010000,
        S_DVD  = 9'b000100000,
        S_MUL  = 9'b001000000,
        S_COMB = 9'b010000000,
        S_OUT  = 9'b100000000
    } t_state;

    typedef enum logic [1:0] {
        PH_A = 2'd0,
        PH_B = 2'd1,
        PH_R = 2'd2
    } t_phase;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic [3:0]  r_op, n_op;
    logic [31:0] r_bnum_raw, n_bnum_raw, r_bden_raw, n_bden_raw;
    logic [63:0] r_rn, n_rn, r_rd, n_rd;
    logic        r_neg, n_neg;
    logic [63:0] r_gx, n_gx, r_gy, n_gy, r_g, n_g;
    logic [5:0]  r_k, n_k;
    logic [63:0] r_dq, n_dq, r_rem, n_rem;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_an, n_an, r_bn, n_bn;
    logic [31:0] r_anum, n_anum, r_aden, n_aden, r_bnum, n_bnum, r_bden, n_bden;
    logic [1:0]  r_mstep, n_mstep;
    logic [63:0] r_p0, n_p0, r_p1, n_p1, r_p2, n_p2;
    logic        r_cmp, n_cmp, r_dz, n_dz;
    rau_pkg::t_res n_res;
    logic        n_done;

    // Shared divider step, multiplier and sign-magnitude adder.
    logic [64:0] dv_t;
    logic        dv_ge;
    logic [63:0] dv_rem, dv_q;
    logic [31:0] mx, my;
    logic [63:0] prod;
    logic        sa_bneg, sn, eq, lt, red_done;
    logic [63:0] sm, sat_n, sat_d;
    logic        ovf;
    logic [31:0] amag, bm, bdm;

    assign busy = (r_state != S_IDLE);

    always_comb begin
        dv_t   = {r_rem, r_dq[63]};
        dv_ge  = (dv_t >= {1'b0, r_g});
        dv_rem = dv_ge ? 64'(dv_t - {1'b0, r_g}) : dv_t[63:0];
        dv_q   = {r_dq[62:0], dv_ge};
    end

    // Multiplier operand selection per step and opcode.
    always_comb begin
        case (r_mstep)
            2'd0: begin
                mx = r_anum;
                my = (r_op == rau_pkg::OP_MUL) ? r_bnum : r_bden;
            end
            2'd1: begin
                mx = r_bnum;
                my = r_aden;
            end
            default: begin
                mx = r_aden;
                my = (r_op == rau_pkg::OP_DIV) ? r_bnum : r_bden;
            end
        endcase
        prod = 64'(mx) * 64'(my);
    end

    // Signed sum of a and the (possibly negated) second cross product.
    always_comb begin
        sa_bneg = r_bn ^ (r_op != rau_pkg::OP_ADD);
        if (r_an == sa_bneg) begin
            sm = r_p0 + r_p1;
            sn = r_an;
        end else if (r_p0 >= r_p1) begin
            sm = r_p0 - r_p1;
            sn = r_an;
        end else begin
            sm = r_p1 - r_p0;
            sn = sa_bneg;
        end
        eq = (sm == 64'd0);
        lt = !eq && sn;
    end

    // Saturation of the final reduced value.
    always_comb begin
        ovf   = 1'b0;
        sat_n = r_rn;
        sat_d = r_rd;
        if (r_neg ? (r_rn > NMAX) : (r_rn > PMAX)) begin
            sat_n = r_neg ? NMAX : PMAX;
            ovf   = 1'b1;
        end
        if (r_rd > PMAX) begin
            sat_d = PMAX;
            ovf   = 1'b1;
        end
        n_res.res_num  = r_neg ? (32'd0 - sat_n[31:0]) : sat_n[31:0];
        n_res.res_den  = sat_d[30:0];
        n_res.cmp_true = r_cmp;
        n_res.div_zero = r_dz;
        n_res.overflow = ovf;
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;  n_phase = r_phase;  n_op = r_op;
        n_bnum_raw = r_bnum_raw;  n_bden_raw = r_bden_raw;
        n_rn = r_rn;  n_rd = r_rd;  n_neg = r_neg;
        n_gx = r_gx;  n_gy = r_gy;  n_g = r_g;  n_k = r_k;
        n_dq = r_dq;  n_rem = r_rem;  n_cnt = r_cnt;
        n_an = r_an;  n_bn = r_bn;
        n_anum = r_anum;  n_aden = r_aden;  n_bnum = r_bnum;  n_bden = r_bden;
        n_mstep = r_mstep;
        n_p0 = r_p0;  n_p1 = r_p1;  n_p2 = r_p2;
        n_cmp = r_cmp;  n_dz = r_dz;
        n_done = 1'b0;
        red_done = 1'b0;
        amag = rau_pkg::mag32(i_req.a_den);
        bm   = rau_pkg::mag32(r_bnum_raw);
        bdm  = rau_pkg::mag32(r_bden_raw);
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op = i_req.op;
                    n_bnum_raw = i_req.b_num;
                    n_bden_raw = i_req.b_den;
                    n_rn = 64'(rau_pkg::mag32(i_req.a_num));
                    n_rd = (amag == 32'd0) ? 64'd1 : 64'(amag);
                    n_neg = i_req.a_num[31] ^ ((amag != 32'd0) && i_req.a_den[31]);
                    n_cmp = 1'b0;
                    n_dz = 1'b0;
                    n_phase = PH_A;
                    n_state = S_RED;
                end
            end
            S_RED: begin
                if (r_rn == 64'd0) begin
                    n_rd = 64'd1;
                    n_neg = 1'b0;
                    red_done = 1'b1;
                end else begin
                    n_gx = r_rn;
                    n_gy = r_rd;
                    n_k = 6'd0;
                    n_state = S_GSH;
                end
            end
            S_GSH: begin
                // Strip common factors of two.
                if (!r_gx[0] && !r_gy[0]) begin
                    n_gx = r_gx >> 1;
                    n_gy = r_gy >> 1;
                    n_k = r_k + 6'd1;
                end else begin
                    n_state = S_GLP;
                end
            end
            S_GLP: begin
                // Binary GCD on the odd parts.
                if (!r_gx[0]) begin
                    n_gx = r_gx >> 1;
                end else if (!r_gy[0]) begin
                    n_gy = r_gy >> 1;
                end else if (r_gx == r_gy) begin
                    n_g = r_gx << r_k;
                    n_dq = r_rn;
                    n_rem = 64'd0;
                    n_cnt = 6'd0;
                    n_state = S_DVN;
                end else if (r_gx > r_gy) begin
                    n_gx = r_gx - r_gy;
                end else begin
                    n_gy = r_gy - r_gx;
                end
            end
            S_DVN: begin
                n_dq = dv_q;
                n_rem = dv_rem;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    n_rn = dv_q;
                    n_dq = r_rd;
                    n_rem = 64'd0;
                    n_cnt = 6'd0;
                    n_state = S_DVD;
                end
            end
            S_DVD: begin
                n_dq = dv_q;
                n_rem = dv_rem;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    n_rd = dv_q;
                    red_done = 1'b1;
                end
            end
            S_MUL: begin
                n_mstep = r_mstep + 2'd1;
                case (r_mstep)
                    2'd0: n_p0 = prod;
                    2'd1: n_p1 = prod;
                    default: begin
                        n_p2 = prod;
                        n_state = S_COMB;
                    end
                endcase
            end
            S_COMB: begin
                n_phase = PH_R;
                n_state = S_RED;
                n_rn = 64'd0;
                n_rd = 64'd1;
                n_neg = 1'b0;
                case (r_op)
                    rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
                        n_rn = sm;
                        n_rd = r_p2;
                        n_neg = sn;
                    end
                    rau_pkg::OP_MUL: begin
                        n_rn = r_p0;
                        n_rd = r_p2;
                        n_neg = r_an ^ r_bn;
                    end
                    rau_pkg::OP_DIV: begin
                        n_rn = r_p0;
                        if (r_bnum == 32'd0) begin
                            n_dz = 1'b1;
                            n_neg = r_an;
                        end else begin
                            n_rd = r_p2;
                            n_neg = r_an ^ r_bn;
                        end
                    end
                    rau_pkg::OP_EQ: n_cmp = eq;
                    rau_pkg::OP_NE: n_cmp = !eq;
                    rau_pkg::OP_LT: n_cmp = lt;
                    rau_pkg::OP_LE: n_cmp = lt || eq;
                    rau_pkg::OP_GT: n_cmp = !lt && !eq;
                    rau_pkg::OP_GE: n_cmp = !lt;
                    default: n_cmp = 1'b0;
                endcase
            end
            S_OUT: begin
                n_done = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase

        // Hand the reduced fraction on according to the phase.
        if (red_done) begin
            case (r_phase)
                PH_A: begin
                    n_an = n_neg;
                    n_anum = n_rn[31:0];
                    n_aden = n_rd[31:0];
                    n_rn = 64'(bm);
                    n_rd = (bdm == 32'd0) ? 64'd1 : 64'(bdm);
                    n_neg = r_bnum_raw[31] ^ ((bdm != 32'd0) && r_bden_raw[31]);
                    n_phase = PH_B;
                    n_state = S_RED;
                end
                PH_B: begin
                    n_bn = n_neg;
                    n_bnum = n_rn[31:0];
                    n_bden = n_rd[31:0];
                    n_mstep = 2'd0;
                    n_state = S_MUL;
                end
                default: n_state = S_OUT;
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_done <= 1'b0;
        end else begin
            r_state <= n_state;
            o_done <= n_done;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_phase <= n_phase;  r_op <= n_op;
        r_bnum_raw <= n_bnum_raw;  r_bden_raw <= n_bden_raw;
        r_rn <= n_rn;  r_rd <= n_rd;  r_neg <= n_neg;
        r_gx <= n_gx;  r_gy <= n_gy;  r_g <= n_g;  r_k <= n_k;
        r_dq <= n_dq;  r_rem <= n_rem;  r_cnt <= n_cnt;
        r_an <= n_an;  r_bn <= n_bn;
        r_anum <= n_anum;  r_aden <= n_aden;  r_bnum <= n_bnum;  r_bden <= n_bden;
        r_mstep <= n_mstep;
        r_p0 <= n_p0;  r_p1 <= n_p1;  r_p2 <= n_p2;
        r_cmp <= n_cmp;  r_dz <= n_dz;
        if (n_done) begin
            o_res <= n_res;
        end
    end

    // Checks.
    `RAU_ASSERT_NEXT(a_busy_after_start, start && !busy, busy, "busy not raised")
    `RAU_ASSERT_NEXT(a_done_pulse, o_done, !o_done, "result strobe too long")
    `RAU_ASSERT_IMP(a_den_nonzero, o_done, o_res.res_den != 31'd0, "zero denominator")
    `RAU_ASSERT_IMP(a_gcd_nonzero, r_state == S_GLP, r_gx != 64'd0 && r_gy != 64'd0, "gcd zero")

endmodule

`default_nettype wire

// ----- bench/tb_rational_arithmetic_unit_top.sv -----
`timescale 1ns / 1ps

module tb_rational_arithmetic_unit_top;

    localparam int  WIDTH      = 32;
    localparam int  IDLE_LIMIT = 20000;
    localparam int  RANDOM_CNT = 2000;

    // Sign and magnitude form of a fraction, wide enough for every intermediate.
    typedef struct {
        bit         neg;
        bit [127:0] num;
        bit [127:0] den;
    } t_frac;

    logic            i_clk;
    logic            i_rst_n;
    logic            start;
    logic            busy;
    rau_pkg::t_req   i_req;
    rau_pkg::t_res   o_res;
    logic            o_done;

    rau_pkg::t_req   pending_reqs[$];
    rau_pkg::t_res   expected_results[$];
    int     fail_count;
    int     idle_cycles;
    int     accepted_reqs;
    int     checked_results;
    bit     quiet_phase;
    int     op_seen[16];

    rational_arithmetic_unit_top #(.WIDTH(WIDTH)) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_req  (i_req),
        .o_res  (o_res),
        .o_done (o_done)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Greatest common divisor by Euclid.
    function automatic bit [127:0] gcd_wide(bit [127:0] x, bit [127:0] y);
        bit [127:0] r;
        while (y != 0) begin
            r = x % y;
            x = y;
            y = r;
        end
        return x;
    endfunction

    // Reduce a fraction to lowest terms; zero is always 0 over 1.
    function automatic t_frac reduce_frac(bit neg, bit [127:0] num, bit [127:0] den);
        t_frac      f;
        bit [127:0] g;
        if (den == 0) den = 1;
        g = gcd_wide(num, den);
        f.num = num / g;
        f.den = den / g;
        f.neg = neg && (f.num != 0);
        if (f.num == 0) f.den = 1;
        return f;
    endfunction

    // Normalize one input fraction: zero denominator is one, sign on the numerator.
    function automatic t_frac normalize(logic signed [31:0] n, logic signed [31:0] d);
        bit         nn;
        bit         dn;
        bit [127:0] nm;
        bit [127:0] dm;
        nn = n[31];
        dn = d[31];
        nm = nn ? (128'h1_0000_0000 - {96'd0, n}) : {96'd0, n};
        dm = dn ? (128'h1_0000_0000 - {96'd0, d}) : {96'd0, d};
        if (dm == 0) begin
            dm = 1;
            dn = 1'b0;
        end
        return reduce_frac(nn != dn, nm, dm);
    endfunction

    // Signed sum of two sign-magnitude values.
    function automatic bit [127:0] signed_sum(bit an, bit [127:0] am, bit bn,
                                               bit [127:0] bm, output bit rn);
        if (an == bn) begin
            rn = an;
            return am + bm;
        end
        if (am >= bm) begin
            rn = an;
            return am - bm;
        end
        rn = bn;
        return bm - am;
    endfunction

    // Expected result of one request item.
    function automatic rau_pkg::t_res rational_result(rau_pkg::t_req q);
        t_frac         a;
        t_frac         b;
        t_frac         r;
        rau_pkg::t_res res;
        bit            dz;
        bit            cmp;
        bit            sn;
        bit            ovf;
        bit            eq;
        bit            lt;
        bit [127:0]    sm;
        bit [127:0]    pmax;
        bit [127:0]    nmax;
        bit [127:0]    n;
        bit [127:0]    d;
        a = normalize(q.a_num, q.a_den);
        b = normalize(q.b_num, q.b_den);
        r.neg = 1'b0;
        r.num = 0;
        r.den = 1;
        dz  = 1'b0;
        cmp = 1'b0;
        case (q.op)
            rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
                sm = signed_sum(a.neg, a.num * b.den,
                                (q.op == rau_pkg::OP_SUB) ? !b.neg : b.neg,
                                b.num * a.den, sn);
                r = reduce_frac(sn, sm, a.den * b.den);
            end
            rau_pkg::OP_MUL: r = reduce_frac(a.neg != b.neg, a.num * b.num, a.den * b.den);
            rau_pkg::OP_DIV: begin
                if (b.num == 0) begin
                    dz = 1'b1;
                    r = reduce_frac(a.neg, a.num * b.den, 1);
                end else begin
                    r = reduce_frac(a.neg != b.neg, a.num * b.den, a.den * b.num);
                end
            end
            rau_pkg::OP_EQ, rau_pkg::OP_NE, rau_pkg::OP_LT, rau_pkg::OP_LE,
            rau_pkg::OP_GT, rau_pkg::OP_GE: begin
                sm = signed_sum(a.neg, a.num * b.den, !b.neg, b.num * a.den, sn);
                eq = (sm == 0);
                lt = !eq && sn;
                case (q.op)
                    rau_pkg::OP_EQ: cmp = eq;
                    rau_pkg::OP_NE: cmp = !eq;
                    rau_pkg::OP_LT: cmp = lt;
                    rau_pkg::OP_LE: cmp = lt || eq;
                    rau_pkg::OP_GT: cmp = !lt && !eq;
                    default:        cmp = !lt;
                endcase
            end
            default: ;
        endcase
        // Saturate each field on its own into the result range.
        pmax = (128'd1 << (WIDTH - 1)) - 1;
        nmax = 128'd1 << (WIDTH - 1);
        ovf  = 1'b0;
        n    = r.num;
        d    = r.den;
        if (r.neg ? (n > nmax) : (n > pmax)) begin
            n   = r.neg ? nmax : pmax;
            ovf = 1'b1;
        end
        if (d > pmax) begin
            d   = pmax;
            ovf = 1'b1;
        end
        res.res_num  = r.neg ? (32'd0 - n[31:0]) : n[31:0];
        res.res_den  = d[30:0];
        res.cmp_true = cmp;
        res.div_zero = dz;
        res.overflow = ovf;
        return res;
    endfunction

    // Field value biased toward the interesting corners.
    function automatic logic [31:0] pick_field();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'd0;
            3:       return 32'hFFFF_FFFF;
            4, 5:    return 32'($signed($urandom_range(0, 40)) - 20);
            6:       return 32'($urandom_range(0, 2000)) * 32'($urandom_range(1, 12));
            default: return $urandom();
        endcase
    endfunction

    task automatic queue_req(logic [3:0] op, logic [31:0] an, logic [31:0] ad,
                             logic [31:0] bn, logic [31:0] bd);
        rau_pkg::t_req q;
        q.op    = op;
        q.a_num = an;
        q.a_den = ad;
        q.b_num = bn;
        q.b_den = bd;
        pending_reqs.push_back(q);
    endtask

    // Stimulus: directed corners first, then random items.
    initial begin
        rau_pkg::t_req q;
        for (int op = 0; op < 16; op++)
            queue_req(op[3:0], 32'sd3, 32'sd4, -32'sd5, 32'sd6);
        queue_req(rau_pkg::OP_DIV, 32'sd7, 32'sd2, 32'sd0, 32'sd9);
        queue_req(rau_pkg::OP_DIV, 32'h8000_0000, 32'sd1, 32'sd0, 32'h8000_0000);
        queue_req(rau_pkg::OP_ADD, 32'sd5, 32'sd0, -32'sd5, 32'sd0);
        queue_req(rau_pkg::OP_MUL, 32'h8000_0000, 32'sd1, 32'h8000_0000, 32'sd1);
        queue_req(rau_pkg::OP_MUL, 32'sd1, 32'h7FFF_FFFF, 32'sd1, 32'h8000_0000);
        queue_req(rau_pkg::OP_SUB, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'hFFFF_FFFF);
        queue_req(rau_pkg::OP_EQ, 32'sd2, 32'sd4, -32'sd1, -32'sd2);
        queue_req(rau_pkg::OP_GE, 32'h8000_0000, 32'sd1, 32'h7FFF_FFFF, 32'h8000_0000);
        for (int i = 0; i < RANDOM_CNT; i++) begin
            q.op    = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                                   : 4'($urandom_range(0, 9));
            q.a_num = pick_field();
            q.a_den = pick_field();
            q.b_num = pick_field();
            q.b_den = pick_field();
            pending_reqs.push_back(q);
        end
    end

    // Driver: offers items from the queue with random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            i_req <= '0;
        end else if (!(start && busy)) begin
            if (pending_reqs.size() > 0 && (quiet_phase || $urandom_range(0, 99) >= 26)) begin
                i_req <= pending_reqs.pop_front();
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // The middle part of the run has no gaps at all.
    always @(posedge i_clk) begin
        quiet_phase <= (accepted_reqs >= 800 && accepted_reqs < 1100);
    end

    // Monitor: predicts on acceptance and checks each completed item.
    always @(posedge i_clk) begin
        rau_pkg::t_res want;
        if (i_rst_n) begin
            if (start && !busy) begin
                expected_results.push_back(rational_result(i_req));
                op_seen[i_req.op]++;
                accepted_reqs++;
            end
            if (o_done) begin
                checked_results++;
                if (expected_results.size() == 0) begin
                    $error("result with nothing expected: num %0d den %0d",
                           o_res.res_num, o_res.res_den);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_res.res_num !== want.res_num) begin
                        $error("res_num: expected %0d, got %0d", want.res_num, o_res.res_num);
                        fail_count++;
                    end
                    if (o_res.res_den !== want.res_den) begin
                        $error("res_den: expected %0d, got %0d", want.res_den, o_res.res_den);
                        fail_count++;
                    end
                    if (o_res.cmp_true !== want.cmp_true) begin
                        $error("cmp_true: expected %0b, got %0b", want.cmp_true, o_res.cmp_true);
                        fail_count++;
                    end
                    if (o_res.div_zero !== want.div_zero) begin
                        $error("div_zero: expected %0b, got %0b", want.div_zero, o_res.div_zero);
                        fail_count++;
                    end
                    if (o_res.overflow !== want.overflow) begin
                        $error("overflow: expected %0b, got %0b", want.overflow, o_res.overflow);
                        fail_count++;
                    end
                end
            end
            // Watchdog on cycles with no accepted item in either direction.
            if ((start && !busy) || o_done) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end
    end

    // Reset, then wait for everything to drain.
    initial begin
        int tail;
        fail_count      = 0;
        idle_cycles     = 0;
        accepted_reqs   = 0;
        checked_results = 0;
        quiet_phase     = 1'b0;
        foreach (op_seen[i]) op_seen[i] = 0;
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_req   = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while ((pending_reqs.size() > 0 || start || expected_results.size() > 0)
               && idle_cycles < IDLE_LIMIT)
            @(posedge i_clk);
        tail = 0;
        while (tail < 1000 && idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            tail++;
        end
        if (idle_cycles >= IDLE_LIMIT || expected_results.size() > 0) begin
            if (idle_cycles >= IDLE_LIMIT) $display("timeout with no progress");
            else $error("%0d expected results never arrived", expected_results.size());
            $display("rational_arithmetic_unit_top: mismatch");
        end else begin
            $display("Ran %0d items over all opcodes, %0d results checked.",
                     accepted_reqs, checked_results);
            $display("Add %0d, div %0d, compare eq %0d, unused opcode 15 %0d.",
                     op_seen[rau_pkg::OP_ADD], op_seen[rau_pkg::OP_DIV],
                     op_seen[rau_pkg::OP_EQ], op_seen[15]);
            if (fail_count == 0) $display("rational_arithmetic_unit_top: match");
            else $display("rational_arithmetic_unit_top: mismatch");
        end
        $finish;
    end

endmodule
